@@ rtl/sldf_pkg.sv @@
package sldf_pkg;

  localparam int unsigned BUF_DEPTH = 256;
  localparam int unsigned SYNC_W = 31;
  localparam logic [SYNC_W-1:0] SYNC_RESET = 31'h3CC3817E;
  localparam logic [SYNC_W-1:0] HDR_TOP = 31'h40000000;
  localparam logic [7:0] MOD_BASE = 8'd255;
  localparam logic [7:0] BIT_MSB = 8'h80;
  localparam logic [2:0] FILL_RELOAD = 3'd7;
  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef enum logic [1:0] {
    KIND_FILLER  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_BUSY    = 2'd3
  } kind_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic       valid;
    logic       from_store;
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

@@ rtl/sldf_store.sv @@
module sldf_store import sldf_pkg::*; #(
  parameter int unsigned Depth = BUF_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sldf_ctrl.sv @@
module sldf_ctrl import sldf_pkg::*; #(
  parameter int unsigned Depth = BUF_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SYNC_W-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  logic              drain_i,
  input  logic              bit_i,
  output res_t              res_o,
  output mem_ctl_t          mem_ctl_o,
  output logic [AddrW-1:0]  mem_addr_o,
  output logic [7:0]        mem_wdata_o
);

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_PAY  = 6'b000100,
    PH_CHK0 = 6'b001000,
    PH_CHK1 = 6'b010000,
    PH_HOLD = 6'b100000
  } phase_e;

  function automatic logic [7:0] mod_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_BASE}) begin
      s = s - {1'b0, MOD_BASE};
    end
    return s[7:0];
  endfunction

  phase_e            phase_q, phase_d;
  logic [SYNC_W-1:0] sync_q, hdr_q, hdr_d;
  logic [2:0]        fill_q, fill_d, bcnt_q, bcnt_d;
  logic [7:0]        bsh_q, bsh_d, flen_q, flen_d, idx_q, idx_d;
  logic [7:0]        slo_q, slo_d, shi_q, shi_d;
  logic [7:0]        gathered, idx_inc, slo_add, shi_add;

  assign gathered = {bit_i, bsh_q[7:1]};
  assign idx_inc  = idx_q + 8'd1;
  assign slo_add  = mod_add(slo_q, gathered);
  assign shi_add  = mod_add(shi_q, slo_add);
  assign mem_addr_o  = idx_q[AddrW-1:0];
  assign mem_wdata_o = gathered;

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    fill_d  = fill_q;
    bcnt_d  = bcnt_q;
    bsh_d   = bsh_q;
    flen_d  = flen_q;
    idx_d   = idx_q;
    slo_d   = slo_q;
    shi_d   = shi_q;
    res_o   = '{valid: 1'b0, from_store: 1'b0, kind: KIND_FILLER, data: 8'd0, last: 1'b0};
    mem_ctl_o = '{we: 1'b0, re: 1'b0};
    if (accept_i) begin
      if (drain_i) begin
        if (phase_q == PH_HOLD) begin
          mem_ctl_o.re     = 1'b1;
          res_o.valid      = 1'b1;
          res_o.from_store = 1'b1;
          res_o.kind       = KIND_PAYLOAD;
          idx_d            = idx_inc;
          if (idx_inc == flen_q) begin
            res_o.last = 1'b1;
            phase_d    = PH_HUNT;
            flen_d     = 8'd0;
            fill_d     = 3'd0;
          end
        end
      end else if (phase_q == PH_HOLD) begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_BUSY;
      end else if (phase_q == PH_HUNT) begin
        if (!bit_i) begin
          if (hdr_q == sync_q) begin
            phase_d = PH_LEN;
            hdr_d   = '0;
            bsh_d   = 8'd0;
            bcnt_d  = 3'd0;
          end else begin
            hdr_d = hdr_q >> 1;
          end
        end else begin
          hdr_d = HDR_TOP | (hdr_q >> 1);
          if (fill_q == 3'd0) begin
            fill_d      = FILL_RELOAD;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_FILLER;
          end else begin
            fill_d = fill_q - 3'd1;
          end
        end
      end else if (bcnt_q != BIT_LAST) begin
        bsh_d  = gathered;
        bcnt_d = bcnt_q + 3'd1;
      end else begin
        bsh_d  = 8'd0;
        bcnt_d = 3'd0;
        case (phase_q)
          PH_LEN: begin
            flen_d = gathered;
            idx_d  = 8'd0;
            slo_d  = mod_add(8'd0, gathered);
            shi_d  = mod_add(8'd0, gathered);
            if (gathered == 8'd0) begin
              phase_d = PH_HUNT;
              flen_d  = 8'd0;
            end else begin
              phase_d = PH_PAY;
            end
          end
          PH_PAY: begin
            mem_ctl_o.we = 1'b1;
            idx_d        = idx_inc;
            slo_d        = slo_add;
            shi_d        = shi_add;
            if (idx_inc == flen_q) begin
              phase_d = PH_CHK0;
            end
          end
          PH_CHK0: begin
            if (gathered == slo_q) begin
              phase_d = PH_CHK1;
            end else begin
              phase_d = PH_HUNT;
              flen_d  = 8'd0;
            end
          end
          PH_CHK1: begin
            if (gathered == shi_q) begin
              phase_d     = PH_HOLD;
              idx_d       = 8'd0;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_LENGTH;
              res_o.data  = flen_q;
            end else begin
              phase_d = PH_HUNT;
              flen_d  = 8'd0;
            end
          end
          default: begin
            phase_d = PH_HUNT;
            flen_d  = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sync_q  <= SYNC_RESET;
      hdr_q   <= '0;
      fill_q  <= 3'd0;
      bcnt_q  <= 3'd0;
      bsh_q   <= 8'd0;
      flen_q  <= 8'd0;
      idx_q   <= 8'd0;
      slo_q   <= 8'd0;
      shi_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      fill_q  <= fill_d;
      bcnt_q  <= bcnt_d;
      bsh_q   <= bsh_d;
      flen_q  <= flen_d;
      idx_q   <= idx_d;
      slo_q   <= slo_d;
      shi_q   <= shi_d;
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ rtl/sync_length_fletcher_deframer_unit.sv @@
// Deframer for a bit stream with a 31-bit sync word, a length byte, payload
// and a two-byte Fletcher-16 check.
// Input stream: each transaction is one item; tuser selects a sample bit (0)
// or a drain tick (1), and tdata bit 0 carries the sample bit.
// Output stream: tdata is the byte, tuser its kind (filler, length, payload,
// busy) and tlast marks the final payload byte of a frame.
// The configuration write port sets the sync word.
// A result appears on the output in the cycle after the input transaction that
// causes it; one input item is taken every cycle while the input is ready, with
// payload bytes read from a synchronous buffer memory addressed by drain index.
// When the receiver stalls, the result waits in the output register and the
// input stays ready only while that register is empty or being emptied.
// Reset returns the control state to hunting and restores the default sync
// word; the payload buffer is not cleared, as a frame is only drained from
// entries that it has written itself.
module sync_length_fletcher_deframer_unit import sldf_pkg::*; #(
  parameter int unsigned BufDepth = BUF_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,  // [0] sample_bit
  input  logic              s_axis_tuser_i,  // [0] req_type
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0]        m_axis_tuser_o,  // [1:0] out_kind
  output logic              m_axis_tlast_o,
  input  logic              cfg_we_i,
  input  logic [SYNC_W-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(BufDepth);

  logic             accept;
  res_t             res, res_q;
  logic             out_valid_q, out_valid_d;
  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  sldf_ctrl #(
    .Depth (BufDepth),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .drain_i     (s_axis_tuser_i),
    .bit_i       (s_axis_tdata_i[0]),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  sldf_store #(
    .Depth (BufDepth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q.from_store ? mem_rdata : res_q.data;
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sldf_pkg::*;

  localparam int unsigned PRESSURE_SEG = 4;
  localparam int unsigned SEG_COUNT = 5;
  localparam int unsigned SEG_ITEMS = 32;
  localparam int unsigned LONG_HOLD = 300;

  typedef enum logic [2:0] {
    ST_HUNT, ST_LEN, ST_PAY, ST_CHK0, ST_CHK1, ST_HOLD
  } deframe_state_e;

  typedef enum int unsigned {
    FR_GOOD, FR_ZERO_LEN, FR_BAD_LO, FR_LO_255, FR_BAD_HI, FR_CUT
  } frame_form_e;

  typedef struct packed {
    logic drain;
    logic sbit;
  } bit_item_t;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } deframed_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i = 8'h00;
  logic              s_axis_tuser_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [7:0]        m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;
  logic              cfg_we_i = 1'b0;
  logic [SYNC_W-1:0] cfg_wdata_i = '0;

  bit_item_t   bit_items[$];
  deframed_t   deframed_q[$];
  bit_item_t   next_item;
  int unsigned queued_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned seg_no = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // Predicted state of the deframer.
  logic [SYNC_W-1:0] sync_cfg = SYNC_RESET;
  deframe_state_e    ph = ST_HUNT;
  logic [SYNC_W-1:0] hdr = '0;
  logic [2:0]        fill_cnt = '0;
  logic [7:0]        shreg = '0;
  logic [2:0]        nbits = '0;
  logic [7:0]        flen = '0;
  logic [7:0]        idx = '0;
  logic [7:0]        s_lo = '0;
  logic [7:0]        s_hi = '0;
  logic [7:0]        store [BUF_DEPTH];

  sync_length_fletcher_deframer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  function automatic logic [7:0] fold255(logic [7:0] acc, logic [7:0] b);
    return 8'((int'(acc) + int'(b)) % int'(MOD_BASE));
  endfunction

  task automatic deframe_step(input logic drain, input logic sbit);
    deframed_t  r;
    logic [7:0] b;
    logic       emit;
    emit = 1'b0;
    r.data = 8'h00;
    r.kind = KIND_FILLER;
    r.last = 1'b0;
    if (drain) begin
      if (ph == ST_HOLD) begin
        r.data = store[idx];
        r.kind = KIND_PAYLOAD;
        emit = 1'b1;
        idx = idx + 8'd1;
        if (idx == flen) begin
          r.last = 1'b1;
          ph = ST_HUNT;
          flen = '0;
          fill_cnt = '0;
        end
      end
    end else if (ph == ST_HOLD) begin
      r.kind = KIND_BUSY;
      emit = 1'b1;
    end else if (ph == ST_HUNT) begin
      if (!sbit) begin
        if (hdr == sync_cfg) begin
          ph = ST_LEN;
          hdr = '0;
          shreg = '0;
          nbits = '0;
        end else begin
          hdr = hdr >> 1;
        end
      end else begin
        hdr = HDR_TOP | (hdr >> 1);
        if (fill_cnt == 3'd0) begin
          fill_cnt = FILL_RELOAD;
          emit = 1'b1;
        end else begin
          fill_cnt = fill_cnt - 3'd1;
        end
      end
    end else begin
      shreg = {sbit, shreg[7:1]};
      if (nbits != BIT_LAST) begin
        nbits = nbits + 3'd1;
      end else begin
        nbits = '0;
        b = shreg;
        shreg = '0;
        case (ph)
          ST_LEN: begin
            flen = b;
            idx = '0;
            s_lo = fold255(8'h00, b);
            s_hi = s_lo;
            if (b == 8'h00) begin
              ph = ST_HUNT;
              flen = '0;
            end else begin
              ph = ST_PAY;
            end
          end
          ST_PAY: begin
            store[idx] = b;
            idx = idx + 8'd1;
            s_lo = fold255(s_lo, b);
            s_hi = fold255(s_hi, s_lo);
            if (idx == flen) ph = ST_CHK0;
          end
          ST_CHK0: begin
            if (b == s_lo) begin
              ph = ST_CHK1;
            end else begin
              ph = ST_HUNT;
              flen = '0;
            end
          end
          default: begin
            if (b == s_hi) begin
              ph = ST_HOLD;
              idx = '0;
              r.data = flen;
              r.kind = KIND_LENGTH;
              emit = 1'b1;
            end else begin
              ph = ST_HUNT;
              flen = '0;
            end
          end
        endcase
      end
    end
    if (emit) deframed_q.push_back(r);
  endtask

  task automatic push_item(input logic drain, input logic sbit);
    bit_items.push_back('{drain: drain, sbit: sbit});
    queued_cnt++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(39) == 0) push_item(1'b1, 1'($urandom_range(1)));
      push_item(1'b0, b[i]);
    end
  endtask

  task automatic queue_noise(input int unsigned n);
    for (int i = 0; i < n; i++) push_item($urandom_range(15) == 0, 1'($urandom_range(1)));
  endtask

  // The leading 1 bit clears any partial sync so the frame lands where intended.
  task automatic queue_frame(input frame_form_e form, input int unsigned len);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] pay;
    push_item(1'b0, 1'b1);
    for (int i = 0; i < SYNC_W; i++) push_item(1'b0, sync_cfg[i]);
    push_item(1'b0, 1'b0);
    if (form == FR_ZERO_LEN) begin
      push_byte(8'h00);
      return;
    end
    lo = fold255(8'h00, 8'(len));
    hi = lo;
    push_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      if (form == FR_CUT && i == len / 2) return;
      pay = 8'($urandom());
      push_byte(pay);
      lo = fold255(lo, pay);
      hi = fold255(hi, lo);
    end
    case (form)
      FR_BAD_LO: push_byte(lo + 8'd1);
      FR_LO_255: push_byte(8'hFF);
      FR_BAD_HI: begin
        push_byte(lo);
        push_byte(hi + 8'd1);
      end
      default: begin
        push_byte(lo);
        push_byte(hi);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(7) == 0) push_item(1'b0, 1'($urandom_range(1)));
          push_item(1'b1, 1'($urandom_range(1)));
        end
        if ($urandom_range(3) == 0) push_item(1'b1, 1'b0);
      end
    endcase
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    while (bit_items.size() != 0 || s_axis_tvalid_i || deframed_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("sync_length_fletcher_deframer_unit: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) deframe_step(s_axis_tuser_i, s_axis_tdata_i[0]);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (bit_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = bit_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {7'b0, next_item.sbit};
          s_axis_tuser_i <= next_item.drain;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Once, in the pressure stretch, the receiver holds off long enough for the
  // deframer to back up and refuse further input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (seg_no == PRESSURE_SEG && !hold_done && s_axis_tvalid_i) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (deframed_q.size() == 0) begin
        $error("unexpected transaction: out_byte %0h out_kind %0d last %0b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatch_cnt++;
      end else begin
        if (deframed_q[0].data !== m_axis_tdata_o) begin
          $error("out_byte: expected %0h, actual %0h", deframed_q[0].data, m_axis_tdata_o);
          mismatch_cnt++;
        end
        if (deframed_q[0].kind !== m_axis_tuser_o) begin
          $error("out_kind: expected %0d, actual %0d", deframed_q[0].kind, m_axis_tuser_o);
          mismatch_cnt++;
        end
        if (deframed_q[0].last !== m_axis_tlast_o) begin
          $error("last: expected %0b, actual %0b", deframed_q[0].last, m_axis_tlast_o);
          mismatch_cnt++;
        end
        void'(deframed_q.pop_front());
      end
    end
  end

  initial begin
    logic [SYNC_W-1:0] sync_val;
    int unsigned       seg_end;
    frame_form_e       form;
    int unsigned       len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int s = 0; s < SEG_COUNT; s++) begin
      wait_quiet();
      repeat (4) @(posedge clk_i);
      if (s != 0) begin
        case (s)
          1: sync_val = '0;
          2: sync_val = '1;
          default: sync_val = SYNC_W'($urandom());
        endcase
        @(posedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= sync_val;
        sync_cfg = sync_val;
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      @(negedge clk_i);
      seg_no = s;
      send_idle_pct = (s < 2) ? 25 : (s < PRESSURE_SEG) ? 55 : 0;
      recv_idle_pct = (s < 2) ? 55 : (s < PRESSURE_SEG) ? 25 : 0;
      seg_end = queued_cnt + SEG_ITEMS;
      if (s == 0) begin
        push_item(1'b1, 1'b0);
        push_item(1'b1, 1'b1);
        repeat (9) push_item(1'b0, 1'b1);
        push_item(1'b0, 1'b0);
        push_item(1'b0, 1'b0);
        push_item(1'b0, 1'b1);
        push_item(1'b0, 1'b0);
        queue_frame(FR_GOOD, 1);
        queue_frame(FR_ZERO_LEN, 0);
        queue_frame(FR_BAD_LO, 3);
        queue_frame(FR_LO_255, 2);
        queue_frame(FR_BAD_HI, 2);
        queue_frame(FR_CUT, 4);
        queue_frame(FR_GOOD, 3);
      end
      while (queued_cnt < seg_end) begin
        case ($urandom_range(9))
          6: form = FR_BAD_LO;
          7: form = FR_BAD_HI;
          8: form = ($urandom_range(1) != 0) ? FR_ZERO_LEN : FR_LO_255;
          9: form = FR_CUT;
          default: form = FR_GOOD;
        endcase
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        queue_frame(form, len);
        if ($urandom_range(2) == 0) queue_noise($urandom_range(1, 40));
      end
    end
    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && deframed_q.size() == 0) begin
      $display("sync_length_fletcher_deframer_unit: match");
    end else begin
      $display("sync_length_fletcher_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sldf_pkg.sv
rtl/sldf_store.sv
rtl/sldf_ctrl.sv
rtl/sync_length_fletcher_deframer_unit.sv
bench/tb.sv
